>>> rtl/gf2f_pkg.sv
package gf2f_pkg;

  localparam int unsigned FieldM = 163;
  localparam int unsigned DigitW = 8;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_MUL  = 3'd1;
  localparam logic [2:0] ACT_SQR  = 3'd2;
  localparam logic [2:0] ACT_INV  = 3'd3;
  localparam logic [2:0] ACT_ROOT = 3'd4;

  localparam logic [1:0] SRC_ACC = 2'd0;
  localparam logic [1:0] SRC_A   = 2'd1;
  localparam logic [1:0] SRC_B   = 2'd2;

  typedef logic [FieldM-1:0] elem_t;

  typedef struct packed {
    logic       load;
    logic       mul_start;
    logic [1:0] src_x;
    logic [1:0] src_y;
    logic       acc_from_mul;
    logic       acc_from_add;
    logic       acc_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

  // Multiply by x modulo f: shift and fold bit 163 back into x^7+x^6+x^3+1.
  function automatic elem_t mulx(input elem_t v);
    elem_t r;
    r = {v[FieldM-2:0], 1'b0};
    if (v[FieldM-1]) begin
      r[0] = ~r[0];
      r[3] = ~r[3];
      r[6] = ~r[6];
      r[7] = ~r[7];
    end
    return r;
  endfunction

endpackage

>>> rtl/gf2f_mul.sv
module gf2f_mul #(
  parameter int unsigned DIGIT_W = gf2f_pkg::DigitW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  gf2f_pkg::elem_t x,
  input  gf2f_pkg::elem_t y,
  output gf2f_pkg::elem_t prod,
  output logic            done
);

  localparam int unsigned Steps = (gf2f_pkg::FieldM + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PadW  = Steps * DIGIT_W;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [PadW-1:0] xs;
  gf2f_pkg::elem_t ys;
  gf2f_pkg::elem_t acc;
  gf2f_pkg::elem_t acc_next;
  logic [CntW-1:0] cnt;
  logic            run;

  // MSB-first digit-serial: acc = acc*x^D + digit*y, D bits per cycle.
  always_comb begin
    acc_next = acc;
    for (int i = 0; i < int'(DIGIT_W); i++) begin
      acc_next = gf2f_pkg::mulx(acc_next);
      if (xs[PadW-1-i]) begin
        acc_next = acc_next ^ ys;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CntW'(Steps);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= PadW'(x);
      ys  <= y;
      acc <= '0;
    end else if (run) begin
      xs  <= xs << DIGIT_W;
      acc <= acc_next;
    end
  end

  assign prod = acc;

endmodule

>>> rtl/gf2f_dp.sv
module gf2f_dp #(
  parameter int unsigned DIGIT_W = gf2f_pkg::DigitW
) (
  input  logic              clk,
  input  logic              rst,
  input  gf2f_pkg::dp_cmd_t cmd,
  input  gf2f_pkg::elem_t   a_in,
  input  gf2f_pkg::elem_t   b_in,
  output gf2f_pkg::dp_sts_t sts,
  output gf2f_pkg::elem_t   acc_out
);

  gf2f_pkg::elem_t a;
  gf2f_pkg::elem_t b;
  gf2f_pkg::elem_t acc;
  gf2f_pkg::elem_t x;
  gf2f_pkg::elem_t y;
  gf2f_pkg::elem_t prod;
  logic            mdone;

  function automatic gf2f_pkg::elem_t pick(input logic [1:0] s, input gf2f_pkg::elem_t c,
                                          input gf2f_pkg::elem_t p, input gf2f_pkg::elem_t q);
    gf2f_pkg::elem_t r;
    unique case (s)
      gf2f_pkg::SRC_A: r = p;
      gf2f_pkg::SRC_B: r = q;
      default:         r = c;
    endcase
    return r;
  endfunction

  assign x = pick(cmd.src_x, acc, a, b);
  assign y = pick(cmd.src_y, acc, a, b);

  gf2f_mul #(.DIGIT_W(DIGIT_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (x),
    .y     (y),
    .prod  (prod),
    .done  (mdone)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= a_in;
      b   <= b_in;
      acc <= a_in;
    end else if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_from_add) begin
      acc <= a ^ b;
    end else if (cmd.acc_from_mul) begin
      acc <= prod;
    end
  end

  assign sts.mul_done = mdone;
  assign acc_out      = acc;

endmodule

>>> rtl/gf2f_ctrl.sv
module gf2f_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        action,
  input  logic [7:0]        root_order,
  input  gf2f_pkg::dp_sts_t sts,
  output gf2f_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQW  = 3'd3;
  localparam logic [2:0] S_MU   = 3'd4;
  localparam logic [2:0] S_MUW  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] act;
  logic [7:0] cnt;
  logic [7:0] cnt_next;
  logic [7:0] exp_val;
  logic [15:0] prodn;

  // n*162 mod 163 = (163 - n mod 163) mod 163; n < 256 so one subtract.
  always_comb begin
    prodn   = {8'd0, root_order} >= 16'd163 ? {8'd0, root_order} - 16'd163
                                            : {8'd0, root_order};
    exp_val = (prodn[7:0] == 8'd0) ? 8'd0 : 8'd163 - prodn[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= gf2f_pkg::ACT_ADD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (start && !busy) begin
        act <= action;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
          cnt_next   = (action == gf2f_pkg::ACT_ROOT) ? exp_val : 8'd161;
        end
      end
      S_DISP: begin
        unique case (act)
          gf2f_pkg::ACT_ADD: begin
            cmd.acc_from_add = 1'b1;
            state_next       = S_FIN;
          end
          gf2f_pkg::ACT_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.src_x     = gf2f_pkg::SRC_A;
            cmd.src_y     = gf2f_pkg::SRC_B;
            cnt_next      = 8'd0;
            state_next    = S_SQW;
          end
          gf2f_pkg::ACT_SQR: begin
            cnt_next   = 8'd1;
            state_next = S_SQ;
          end
          gf2f_pkg::ACT_INV: state_next = S_SQ;
          gf2f_pkg::ACT_ROOT: state_next = (cnt == 8'd0) ? S_FIN : S_SQ;
          default: begin
            cmd.acc_clear = 1'b1;
            state_next    = S_FIN;
          end
        endcase
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        state_next    = S_SQW;
      end
      S_SQW: begin
        if (sts.mul_done) begin
          cmd.acc_from_mul = 1'b1;
          if (act == gf2f_pkg::ACT_INV) begin
            if (cnt == 8'd0) begin
              state_next = S_FIN;
            end else begin
              state_next = S_MU;
            end
          end else begin
            cnt_next   = (cnt == 8'd0) ? 8'd0 : cnt - 8'd1;
            state_next = (cnt <= 8'd1) ? S_FIN : S_SQ;
          end
        end
      end
      S_MU: begin
        cmd.mul_start = 1'b1;
        cmd.src_y     = gf2f_pkg::SRC_A;
        state_next    = S_MUW;
      end
      S_MUW: begin
        if (sts.mul_done) begin
          cmd.acc_from_mul = 1'b1;
          cnt_next         = cnt - 8'd1;
          state_next       = S_SQ;
        end
      end
      S_FIN: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> rtl/gf2_163_field_arithmetic.sv
// From the accepting edge to the result: add and unused codes go straight to the
// finish state; multiply and square take one product each; inverse takes 323
// products; nth root takes (163 - n mod 163) mod 163 squarings. With the default
// DIGIT_W of 8, a product is a start, 21 digit steps and a done strobe.
// One item at a time; busy stays high through done, so the next item is taken
// in the cycle after done. Synchronous reset returns the controller to idle; the receiver cannot stall.
module gf2_163_field_arithmetic #(
  parameter int unsigned DIGIT_W = gf2f_pkg::DigitW
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output logic         done,
  input  logic [2:0]   action,
  input  logic [63:0]  operand_a_word0,
  input  logic [63:0]  operand_a_word1,
  input  logic [34:0]  operand_a_word2,
  input  logic [63:0]  operand_b_word0,
  input  logic [63:0]  operand_b_word1,
  input  logic [34:0]  operand_b_word2,
  input  logic [7:0]   root_order,
  output logic [63:0]  result_word0,
  output logic [63:0]  result_word1,
  output logic [34:0]  result_word2
);

  gf2f_pkg::dp_cmd_t cmd;
  gf2f_pkg::dp_sts_t sts;
  gf2f_pkg::elem_t   acc;

  gf2f_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .root_order (root_order),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  gf2f_dp #(.DIGIT_W(DIGIT_W)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .a_in    ({operand_a_word2, operand_a_word1, operand_a_word0}),
    .b_in    ({operand_b_word2, operand_b_word1, operand_b_word0}),
    .sts     (sts),
    .acc_out (acc)
  );

  assign result_word0 = acc[63:0];
  assign result_word1 = acc[127:64];
  assign result_word2 = acc[162:128];

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst) cmd.load |-> !busy)
    else $error("load while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("still busy after done");

endmodule
